// ===== hdl/cli_pkg.sv =====
// Shared types and constants for the column linear interpolator.
package cli_pkg;
  localparam int MaxPoints = 64;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam int WordW = 32;
  localparam int MagW = WordW + 1;
  localparam int ProdW = 2 * MagW;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  localparam logic CFG_POINTS = 1'b0;
  localparam logic CFG_CLAMP = 1'b1;

  localparam logic ACT_LOAD = 1'b0;

  typedef struct packed {
    logic load;
    logic [IdxW-1:0] idx;
    logic signed [WordW-1:0] axis;
    logic signed [WordW-1:0] value;
  } cell_wr_t;

  typedef struct packed {
    logic signed [WordW-1:0] axis;
    logic signed [WordW-1:0] value;
  } pair_t;
endpackage

// ===== hdl/cli_cell.sv =====
// One table cell: holds a pair and rotates it to its neighbor on shift.
module cli_cell (
  input  logic clk,
  input  logic [cli_pkg::IdxW-1:0] my_idx,
  input  cli_pkg::cell_wr_t wr,
  input  logic shift,
  input  cli_pkg::pair_t prev,
  output cli_pkg::pair_t data
);
  cli_pkg::pair_t data_r;
  always_ff @(posedge clk) begin
    if (shift) begin
      data_r <= prev;
    end else if (wr.load && wr.idx == my_idx) begin
      data_r.axis <= wr.axis;
      data_r.value <= wr.value;
    end
  end
  assign data = data_r;
endmodule

// ===== hdl/cli_div.sv =====
// Restoring divider of a product magnitude by a divisor, one bit per cycle.
module cli_div (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic [cli_pkg::ProdW-1:0] num,
  input  logic [cli_pkg::MagW-1:0] den,
  output logic done,
  output logic [cli_pkg::ProdW-1:0] quo
);
  localparam int CW = $clog2(cli_pkg::ProdW + 1);
  logic [cli_pkg::ProdW-1:0] q_r;
  logic [cli_pkg::MagW:0] rem_r, sh;
  logic [cli_pkg::MagW-1:0] d_r;
  logic [CW-1:0] cnt_r;
  logic busy_r, done_r;
  always_comb sh = {rem_r[cli_pkg::MagW-1:0], q_r[cli_pkg::ProdW-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        q_r <= num;
        d_r <= den;
        rem_r <= '0;
        cnt_r <= CW'(cli_pkg::ProdW);
      end else if (busy_r) begin
        if (sh >= {1'b0, d_r}) begin
          rem_r <= sh - {1'b0, d_r};
          q_r <= {q_r[cli_pkg::ProdW-2:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r <= {q_r[cli_pkg::ProdW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
  assign done = done_r;
  assign quo = q_r;
endmodule

// ===== hdl/column_linear_interp.sv =====
// Top level of the column linear interpolator.
// Load beats write one table pair and keep busy low. A query holds busy high while the
// table rotates once through its ring of 64 cells (one pair per cycle, whatever the
// configured point count is), and the S_MUL state then decides the answer. When the target
// falls past the start of a segment with a nonzero slope, the divider is started from a
// register, runs its bit-serial divide steps, and S_DIV takes its result. The result is
// on the out_ ports with out_valid high in the first cycle that busy is low again, for
// that one cycle only, and cannot be stalled.
module column_linear_interp (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic in_action,
  input  logic [5:0] in_entry_index,
  input  logic signed [31:0] in_entry_axis,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_target,
  input  logic cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  output logic out_valid,
  output logic signed [31:0] out_result_value,
  output logic [1:0] out_status
);
  localparam int N = cli_pkg::MaxPoints;
  localparam int W = cli_pkg::WordW;
  localparam int M = cli_pkg::MagW;
  localparam int P = cli_pkg::ProdW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_REST = 5'b00100,
    S_MUL = 5'b01000, S_DIV = 5'b10000
  } state_t;

  state_t state_r;
  logic [cli_pkg::CntW-1:0] pts_r, n_r, cnt_r;
  logic clamp_r;
  logic signed [W-1:0] t_r;
  cli_pkg::pair_t prev_r, first_r, last_r, lo_r, hi_r;
  logic hit_r;
  logic rev_r;
  logic shift;
  cli_pkg::cell_wr_t wr;
  cli_pkg::pair_t cell_q [N];
  logic [M-1:0] ma_r, mb_r, mc_r;
  logic neg_r;
  logic [P-1:0] prod_r;
  logic div_go;
  logic div_go_r;
  logic div_done;
  logic [P-1:0] quo;
  logic vld_r;
  logic signed [W-1:0] res_r;
  logic [1:0] st_r;

  assign wr.load = start && !busy && in_action == cli_pkg::ACT_LOAD;
  assign wr.idx = in_entry_index;
  assign wr.axis = in_entry_axis;
  assign wr.value = in_entry_value;

  for (genvar g = 0; g < N; g++) begin : g_cell
    cli_cell u_cell (
      .clk(clk), .my_idx(cli_pkg::IdxW'(g)), .wr(wr), .shift(shift),
      .prev(cell_q[(g + 1) % N]), .data(cell_q[g])
    );
  end

  cli_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(prod_r), .den(mc_r),
    .done(div_done), .quo(quo)
  );

  cli_pkg::pair_t head;
  logic signed [W:0] ta, tb, tc, ua;
  logic [M-1:0] mag_a, mag_b, mag_c;
  logic brk;
  assign head = cell_q[0];
  assign brk = ((prev_r.axis <= t_r) && (t_r < head.axis)) ||
               ((prev_r.axis >= t_r) && (t_r > head.axis));
  assign shift = (state_r == S_SCAN) || (state_r == S_REST);
  assign div_go = div_go_r;

  always_comb begin
    ta = (W+1)'(t_r) - (W+1)'(lo_r.axis);
    tb = (W+1)'(hi_r.value) - (W+1)'(lo_r.value);
    tc = (W+1)'(hi_r.axis) - (W+1)'(lo_r.axis);
    ua = '0;
    mag_a = ta[W] ? M'(-ta) : M'(ta);
    mag_b = tb[W] ? M'(-tb) : M'(tb);
    mag_c = tc[W] ? M'(-tc) : M'(tc);
  end

  logic signed [P:0] sum;
  logic signed [W:0] wide_q;
  always_comb begin
    wide_q = |quo[P-1:W] ? {1'b0, {W{1'b1}}} : {1'b0, quo[W-1:0]};
    sum = (P+1)'(lo_r.value) + (neg_r ? -(P+1)'(wide_q) : (P+1)'(wide_q));
  end

  function automatic logic signed [W-1:0] sat(input logic signed [P:0] v);
    logic signed [P:0] mx, mn;
    mx = (P+1)'({1'b0, {(W-1){1'b1}}});
    mn = -mx - 1;
    if (v > mx) return {1'b0, {(W-1){1'b1}}};
    if (v < mn) return {1'b1, {(W-1){1'b0}}};
    return v[W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pts_r <= '0;
      clamp_r <= 1'b0;
      vld_r <= 1'b0;
      div_go_r <= 1'b0;
    end else begin
      vld_r <= 1'b0;
      div_go_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          cli_pkg::CFG_POINTS: pts_r <= cfg_data[cli_pkg::CntW-1:0];
          cli_pkg::CFG_CLAMP: clamp_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (start && in_action != cli_pkg::ACT_LOAD) begin
            t_r <= in_target;
            n_r <= (pts_r > cli_pkg::CntW'(N)) ? cli_pkg::CntW'(N) : pts_r;
            cnt_r <= '0;
            hit_r <= 1'b0;
            prev_r <= cell_q[0];
            first_r <= cell_q[0];
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // head is entry cnt_r; once cnt_r is nonzero, prev_r is the one before it
          cnt_r <= cnt_r + 1'b1;
          prev_r <= head;
          if (cnt_r < n_r) begin
            if (brk) begin
              hit_r <= 1'b1;
              lo_r <= prev_r;
              hi_r <= head;
            end
          end
          if (cnt_r + 1'b1 == n_r) last_r <= head;
          if (cnt_r == cli_pkg::CntW'(N - 1)) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          ma_r <= mag_a;
          mb_r <= mag_b;
          mc_r <= mag_c;
          neg_r <= ta[W] ^ tb[W] ^ tc[W];
          prod_r <= P'(mag_a[W-1:0]) * P'(mag_b[W-1:0]);
          if (!hit_r || n_r < cli_pkg::CntW'(2) || tc == '0 || ta == '0 || tb == '0)
          begin
            vld_r <= 1'b1;
            state_r <= S_IDLE;
            res_r <= '0;
            st_r <= cli_pkg::ST_INVALID;
            if (n_r >= cli_pkg::CntW'(2)) begin
              if (hit_r) begin
                res_r <= lo_r.value;
                st_r <= cli_pkg::ST_INTERP;
              end else if (clamp_r) begin
                rev_r <= 1'b0;
                if ((first_r.axis < last_r.axis) ? (t_r < first_r.axis)
                                                  : (t_r > first_r.axis)) begin
                  res_r <= first_r.value;
                  st_r <= cli_pkg::ST_FIRST;
                end else if ((first_r.axis < last_r.axis) ? (t_r > last_r.axis)
                                                           : (t_r < last_r.axis)) begin
                  res_r <= last_r.value;
                  st_r <= cli_pkg::ST_LAST;
                end
              end
            end
          end else begin
            div_go_r <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            vld_r <= 1'b1;
            res_r <= sat(sum);
            st_r <= cli_pkg::ST_INTERP;
            state_r <= S_IDLE;
          end
        end
        S_REST: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = vld_r;
  assign out_result_value = res_r;
  assign out_status = st_r;

  logic unused;
  assign unused = ^{ua, ma_r, mb_r, rev_r};

  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && cnt_r == cli_pkg::CntW'(N - 1)) |=> (state_r == S_MUL))
    else $error("scan did not finish full rotation");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE) else $error("result while busy");
endmodule

// ===== tb/sv/column_linear_interp_tb.sv =====
// Testbench for column_linear_interp: drives table loads and queries, checks results against a scoreboard.
`timescale 1ns / 1ps

module column_linear_interp_tb;
  localparam logic ACT_QUERY = ~cli_pkg::ACT_LOAD;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT = 3000000;

  class interp_scoreboard;
    logic signed [31:0] axis_tab [cli_pkg::MaxPoints];
    logic signed [31:0] value_tab [cli_pkg::MaxPoints];
    int unsigned points;
    bit clamp;
    logic signed [31:0] pend_value [$];
    logic [1:0] pend_status [$];
    int errors;

    function logic signed [31:0] slope_value(int i, longint t);
      longint x0, x1, u0, u1, da, db, dc;
      bit neg;
      logic [67:0] ma, mb, mc, q;
      logic signed [69:0] s;
      x0 = axis_tab[i];
      x1 = axis_tab[i+1];
      u0 = value_tab[i];
      u1 = value_tab[i+1];
      da = t - x0;
      db = u1 - u0;
      dc = x1 - x0;
      if (da == 0 || db == 0 || dc == 0) return u0;
      neg = ((da < 0) != (db < 0)) != (dc < 0);
      ma = da < 0 ? -da : da;
      mb = db < 0 ? -db : db;
      mc = dc < 0 ? -dc : dc;
      q = (ma * mb) / mc;
      s = u0;
      s = neg ? s - $signed({2'b00, q}) : s + $signed({2'b00, q});
      if (s > 70'sd2147483647) return 32'sh7FFFFFFF;
      if (s < -70'sd2147483648) return 32'sh80000000;
      return s[31:0];
    endfunction

    function void note_beat(logic act, logic [5:0] idx, logic signed [31:0] ax,
                            logic signed [31:0] val, logic signed [31:0] tgt);
      int n, found;
      bit hit, rising;
      longint t, a, b, first, last;
      logic signed [31:0] r;
      logic [1:0] st;
      if (act == cli_pkg::ACT_LOAD) begin
        axis_tab[idx] = ax;
        value_tab[idx] = val;
        return;
      end
      t = tgt;
      n = points > cli_pkg::MaxPoints ? cli_pkg::MaxPoints : points;
      r = 0;
      st = cli_pkg::ST_INVALID;
      hit = 0;
      found = 0;
      if (n >= 2) begin
        for (int i = 0; i + 1 < n; i++) begin
          a = axis_tab[i];
          b = axis_tab[i+1];
          if ((a <= t && t < b) || (a >= t && t > b)) begin
            found = i;
            hit = 1;
          end
        end
        first = axis_tab[0];
        last = axis_tab[n-1];
        rising = first < last;
        if (hit) begin
          r = slope_value(found, t);
          st = cli_pkg::ST_INTERP;
        end else if (clamp) begin
          if (rising ? (t < first) : (t > first)) begin
            r = value_tab[0];
            st = cli_pkg::ST_FIRST;
          end else if (rising ? (t > last) : (t < last)) begin
            r = value_tab[n-1];
            st = cli_pkg::ST_LAST;
          end
        end
      end
      pend_value.push_back(r);
      pend_status.push_back(st);
    endfunction

    function void check_result(logic signed [31:0] v, logic [1:0] st);
      logic signed [31:0] ev;
      logic [1:0] es;
      if (pend_value.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time, v, st);
        errors++;
        return;
      end
      ev = pend_value.pop_front();
      es = pend_status.pop_front();
      if (v !== ev) begin
        $display("%0t: result_value expected %h actual %h", $time, ev, v);
        errors++;
      end
      if (st !== es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_action = 0;
  logic [5:0] in_entry_index = 0;
  logic signed [31:0] in_entry_axis = 0;
  logic signed [31:0] in_entry_value = 0;
  logic signed [31:0] in_target = 0;
  logic cfg_we = 0;
  logic [0:0] cfg_index = 0;
  logic [6:0] cfg_data = 0;
  logic out_valid;
  logic signed [31:0] out_result_value;
  logic [1:0] out_status;

  interp_scoreboard sb = new();
  bit no_gaps;
  int cycles;

  column_linear_interp u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_result_value, out_status);

  task automatic send_beat(logic act, logic [5:0] idx, logic signed [31:0] ax,
                           logic signed [31:0] val, logic signed [31:0] tgt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    in_action <= act;
    in_entry_index <= idx;
    in_entry_axis <= ax;
    in_entry_value <= val;
    in_target <= tgt;
    start <= 1;
    do @(posedge clk); while (busy);
    sb.note_beat(act, idx, ax, val, tgt);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pend_value.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [6:0] data);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == cli_pkg::CFG_POINTS) sb.points = data;
    else sb.clamp = data[0];
  endtask

  task automatic load_table(int mode);
    logic signed [31:0] step, ax;
    step = $urandom_range(1, 32'h0400_0000);
    if ($urandom_range(0, 3) == 0) step = $urandom_range(1, 16);
    for (int i = 0; i < cli_pkg::MaxPoints; i++) begin
      case (mode)
        0: ax = 32'sh8000_0000 + i * step;
        1: ax = 32'sh7FFF_FFFF - i * step;
        default: ax = $urandom;
      endcase
      send_beat(cli_pkg::ACT_LOAD, 6'(i), ax, $urandom, 0);
    end
  endtask

  task automatic query(logic signed [31:0] tgt);
    send_beat(ACT_QUERY, 6'($urandom), $urandom, $urandom, tgt);
  endtask

  function automatic logic signed [31:0] pick_target();
    int k;
    k = $urandom_range(0, cli_pkg::MaxPoints - 1);
    case ($urandom_range(0, 6))
      0: return sb.axis_tab[k];
      1: return sb.axis_tab[k] + $signed($urandom_range(0, 32'h0100_0000));
      2: return sb.axis_tab[k] - 1;
      3: return 32'sh8000_0000;
      4: return 32'sh7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sb.points = 0;
    sb.clamp = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    no_gaps = 0;
    query(32'sh0000_1000);
    for (int i = 0; i < cli_pkg::MaxPoints; i++)
      send_beat(cli_pkg::ACT_LOAD, 6'(i),
                32'sh8000_0000 + i * 32'sh0400_0000 + (i == 63 ? 32'sh03FF_FFFF : 0),
                i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000, 0);
    write_cfg(cli_pkg::CFG_POINTS, 7'd1);
    query(32'sh8000_0000);
    write_cfg(cli_pkg::CFG_POINTS, 7'd2);
    query(32'sh8200_0000);
    query(32'sh0000_0000);
    write_cfg(cli_pkg::CFG_POINTS, 7'd127);
    write_cfg(cli_pkg::CFG_CLAMP, 7'd1);
    query(32'sh8000_0000);
    query(32'sh7FFF_FFFF);
    query(32'sh0000_0001);
    send_beat(cli_pkg::ACT_LOAD, 6'd0, 32'sh8000_0010, 32'sh1234_5678, 0);
    query(32'sh8000_0000);
    write_cfg(cli_pkg::CFG_POINTS, 7'd64);
    query(32'sh7FFF_FFFF);

    for (int ph = 0; ph < 8; ph++) begin
      int sel;
      no_gaps = (ph % 3 == 1);
      load_table(ph % 3);
      sel = $urandom_range(0, 5);
      write_cfg(cli_pkg::CFG_POINTS, 7'(sel == 0 ? 0 : sel == 1 ? 1 : sel == 2 ? 2 :
                sel == 3 ? 64 : sel == 4 ? 127 : $urandom_range(3, 70)));
      write_cfg(cli_pkg::CFG_CLAMP, 7'($urandom_range(0, 1)));
      for (int j = 0; j < 110; j++) begin
        if ($urandom_range(0, 4) == 0)
          send_beat(cli_pkg::ACT_LOAD, 6'($urandom), $urandom, $urandom, $urandom);
        else
          query(pick_target());
        if (j == 55) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pend_value.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/cli_pkg.sv
hdl/cli_cell.sv
hdl/cli_div.sv
hdl/column_linear_interp.sv
tb/sv/column_linear_interp_tb.sv
